@@ sv/mrf_pkg.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU request framer package
// Shared request type, frame constants and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package mrf_pkg;

   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;
   localparam logic [7:0]  FN_READ   = 8'h03;
   localparam logic [7:0]  FN_WRITE  = 8'h06;
   localparam logic [7:0]  REG_ADDR  = 8'h40;
   localparam logic [7:0]  REG_COUNT = 8'h02;

   // Positions of the two CRC bytes and the last byte of the frame.
   localparam logic [2:0] POS_CRC_LO = 3'd6;
   localparam logic [2:0] POS_CRC_HI = 3'd7;

   typedef enum logic {
      KIND_READ  = 1'b0,
      KIND_WRITE = 1'b1
   } mrf_kind_type;

   typedef struct packed {
      mrf_kind_type func;
      logic [7:0]   device_id;
      logic [7:0]   new_address;
   } mrf_request_type;

   // Header byte at a given frame position (positions zero to five).
   function automatic logic [7:0] header_byte(mrf_request_type req, logic [2:0] pos);
      logic [7:0] b;
      unique case (pos)
         3'd0:    b = req.device_id;
         3'd1:    b = (req.func == KIND_WRITE) ? FN_WRITE : FN_READ;
         3'd2:    b = 8'h00;
         3'd3:    b = (req.func == KIND_WRITE) ? REG_ADDR : 8'h00;
         3'd4:    b = 8'h00;
         default: b = (req.func == KIND_WRITE) ? req.new_address : REG_COUNT;
      endcase
      return b;
   endfunction

   // One byte through the reflected CRC-16/MODBUS, bit by bit.
   function automatic logic [15:0] crc_update(logic [15:0] crc_in, logic [7:0] b);
      logic [15:0] c;
      c = crc_in ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ sv/modbus_rtu_request_framer.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU request framer
// Turns one request into an eight-byte Modbus RTU frame with CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// A request (req_func, req_device_id, req_new_address) is taken on the req_
// channel when req_valid and req_ready are both high. Kind zero builds a
// read-holding-registers frame for two registers from address zero; kind one
// builds a write-single-register frame that sets register 0x40 to the new
// address. The frame leaves on the rsp_ channel one byte per transfer, the
// two CRC bytes last with the low byte first, and rsp_last_byte marks the
// eighth byte.
// Three CRC stages fold two header bytes each into the checksum, and a
// serializer register holds the finished frame. An accepted request passes
// through the stage registers in order into the serializer, which shows the
// first byte of its frame. The serializer sends one byte per cycle while the
// receiver takes them, and loads the next frame as the last byte is taken.
// Up to four requests can be in flight; when the receiver stalls the bytes
// wait in the serializer, the stages fill behind it and req_ready falls only
// once every stage holds a request. Nothing is lost or repeated.
// Reset is synchronous and empties every stage; no clearing pass is needed.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_device_id,
   input  logic [7:0] req_new_address,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_last_byte
);

   mrf_pkg::mrf_request_type req_in;
   mrf_pkg::mrf_request_type s0_req;
   mrf_pkg::mrf_request_type s1_req;
   mrf_pkg::mrf_request_type s2_req;
   logic [15:0]              s0_crc;
   logic [15:0]              s1_crc;
   logic [15:0]              s2_crc;
   logic                     s0_valid;
   logic                     s1_valid;
   logic                     s2_valid;
   logic                     s0_ready;
   logic                     s1_ready;
   logic                     s2_ready;

   // Pack the request ports into the shared request type.
   always_comb begin
      req_in.func        = mrf_pkg::mrf_kind_type'(req_func);
      req_in.device_id   = req_device_id;
      req_in.new_address = req_new_address;
   end

   // First stage: slave address and function code.
   mrf_crc_stage u_stage0 (
      .clock     (clock),
      .reset     (reset),
      .first_pos (3'd0),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_req    (req_in),
      .in_crc    (mrf_pkg::CRC_INIT),
      .out_valid (s0_valid),
      .out_ready (s0_ready),
      .out_req   (s0_req),
      .out_crc   (s0_crc)
   );

   // Second stage: register address bytes.
   mrf_crc_stage u_stage1 (
      .clock     (clock),
      .reset     (reset),
      .first_pos (3'd2),
      .in_valid  (s0_valid),
      .in_ready  (s0_ready),
      .in_req    (s0_req),
      .in_crc    (s0_crc),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_req   (s1_req),
      .out_crc   (s1_crc)
   );

   // Third stage: count or value bytes; the CRC is complete after it.
   mrf_crc_stage u_stage2 (
      .clock     (clock),
      .reset     (reset),
      .first_pos (3'd4),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_req    (s1_req),
      .in_crc    (s1_crc),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_req   (s2_req),
      .out_crc   (s2_crc)
   );

   mrf_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (s2_valid),
      .in_ready       (s2_ready),
      .in_req         (s2_req),
      .in_crc         (s2_crc),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

   // A frame never breaks off in the middle: after a byte other than the
   // last is taken, the next byte is already waiting.
   a_frame_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_byte |=> rsp_valid)
      else $error("frame stopped before its last byte");

   // Requests are refused only when every stage holds a request.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s0_valid && s1_valid && s2_valid && rsp_valid))
      else $error("request refused while the pipeline has room");

   // A request moved into the serializer starts a fresh frame: the
   // first byte shown is the slave address of that request.
   a_frame_starts_with_address: assert property (@(posedge clock) disable iff (reset)
      s2_valid && s2_ready |=> rsp_frame_byte == $past(s2_req.device_id))
      else $error("frame does not start with the slave address");

endmodule

@@ sv/mrf_crc_stage.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU framer CRC stage
// One pipeline stage that folds two header bytes into the running CRC.
// ----------------------------------------------------------------------------
module mrf_crc_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [2:0]               first_pos,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  mrf_pkg::mrf_request_type in_req,
   input  logic [15:0]              in_crc,
   output logic                     out_valid,
   input  logic                     out_ready,
   output mrf_pkg::mrf_request_type out_req,
   output logic [15:0]              out_crc
);

   logic                     valid_ff;
   logic                     valid_in;
   mrf_pkg::mrf_request_type req_ff;
   logic [15:0]              crc_ff;
   logic [15:0]              crc_mid;
   logic [15:0]              crc_in;
   logic                     load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      crc_mid  = mrf_pkg::crc_update(in_crc, mrf_pkg::header_byte(in_req, first_pos));
      crc_in   = mrf_pkg::crc_update(crc_mid,
                    mrf_pkg::header_byte(in_req, 3'(first_pos + 3'd1)));
      valid_in = load ? 1'b1 : (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         req_ff <= in_req;
         crc_ff <= crc_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_req   = req_ff;
   assign out_crc   = crc_ff;

endmodule

@@ sv/mrf_serializer.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU framer serializer
// Holds one finished frame and hands it out one byte per accepted transfer.
// ----------------------------------------------------------------------------
module mrf_serializer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  mrf_pkg::mrf_request_type in_req,
   input  logic [15:0]              in_crc,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_frame_byte,
   output logic                     rsp_last_byte
);

   logic                     valid_ff;
   logic                     valid_in;
   logic [2:0]               pos_ff;
   logic [2:0]               pos_in;
   mrf_pkg::mrf_request_type req_ff;
   logic [15:0]              crc_ff;
   logic                     last;
   logic                     done;
   logic                     load;

   assign last     = (pos_ff == mrf_pkg::POS_CRC_HI);
   assign done     = valid_ff && rsp_ready && last;
   assign in_ready = !valid_ff || done;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      if (load) begin
         valid_in = 1'b1;
         pos_in   = 3'd0;
      end else if (done) begin
         valid_in = 1'b0;
         pos_in   = 3'd0;
      end else if (valid_ff && rsp_ready) begin
         pos_in   = 3'(pos_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         req_ff <= in_req;
         crc_ff <= in_crc;
      end
   end

   always_comb begin
      if (pos_ff == mrf_pkg::POS_CRC_LO) begin
         rsp_frame_byte = crc_ff[7:0];
      end else if (pos_ff == mrf_pkg::POS_CRC_HI) begin
         rsp_frame_byte = crc_ff[15:8];
      end else begin
         rsp_frame_byte = mrf_pkg::header_byte(req_ff, pos_ff);
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_last_byte = last;

endmodule
